>>> design/fla_pkg.sv
// Shared constants for the free list allocator: sizes, status codes and register indexes.
package fla_pkg;

    localparam int FREE_SLOTS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int ADDRESS_BITS = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_HEAP_FULL = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;

    localparam logic [1:0] CFG_FIT_POLICY = 2'd0;
    localparam logic [1:0] CFG_HEAP_BASE  = 2'd1;
    localparam logic [1:0] CFG_HEAP_LIMIT = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic FIT_BEST   = 1'b1;

endpackage

>>> design/free_list_allocator_unit.sv
// Free list allocator: address-ordered segment table in RAM, sequenced scan, split, merge and shift.
// Allocate scans entry by entry, then splits the picked entry, shifts later entries down to
// remove it, or grows the heap at the break pointer; free scans to its address position, then
// merges with neighbours or shifts entries up to insert. One transfer in flight at a time; the
// result register lets the next transfer be accepted while a result waits. Reset empties the
// table at once (fill count cleared), break pointer to zero, totals to zero.
module free_list_allocator_unit #(
    parameter int FREE_SLOTS   = fla_pkg::FREE_SLOTS,
    parameter int HEADER_BYTES = fla_pkg::HEADER_BYTES,
    parameter int ADDRESS_BITS = fla_pkg::ADDRESS_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [23:0] request_size,
    input  logic [31:0] block_address,
    input  logic [23:0] block_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_address,
    output logic [1:0]  status,
    output logic [31:0] data_segment_bytes,
    output logic [31:0] free_space_bytes
);

    localparam int AB = ADDRESS_BITS;
    localparam int SW = (AB > 32) ? AB : 32;
    localparam int IW = $clog2(FREE_SLOTS);
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam logic [AB-1:0] HB = AB'(HEADER_BYTES);
    localparam logic [SW:0] AMASK = {{(SW+1-AB){1'b0}}, {AB{1'b1}}};

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_A_RD    = 4'd1;
    localparam logic [3:0] S_A_EV    = 4'd2;
    localparam logic [3:0] S_A_APPLY = 4'd3;
    localparam logic [3:0] S_F_RD    = 4'd4;
    localparam logic [3:0] S_F_EV    = 4'd5;
    localparam logic [3:0] S_F_APPLY = 4'd6;
    localparam logic [3:0] S_SH_RD   = 4'd7;
    localparam logic [3:0] S_SH_WR   = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic          fit_policy_reg;
    logic [31:0]   heap_limit_reg;
    logic [AB-1:0] bp_reg;
    logic [31:0]   seg_bytes_reg, free_tot_reg;
    logic [CW-1:0] count_reg, idx_reg, ins_pos_reg;
    logic          shift_up_reg;
    logic [23:0]   req_reg, size_in_reg;
    logic [AB-1:0] hdr_reg;
    logic          found_reg;
    logic [CW-1:0] pick_idx_reg;
    logic [AB-1:0] pick_addr_reg, pick_size_reg;
    logic [AB-1:0] prev_addr_reg, prev_size_reg;
    logic          next_valid_reg;
    logic [AB-1:0] next_addr_reg, next_size_reg;
    logic [2*AB-1:0] ins_entry_reg;
    logic [AB-1:0] res_addr_reg;
    logic [1:0]    res_status_reg;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr, ram_raddr;
    logic [2*AB-1:0] ram_wdata, ram_rdata;
    logic [AB-1:0]   rd_addr, rd_size;

    logic [CW-1:0] idx_inc, idx_dec;
    logic          fits, better;
    logic [SW-1:0] rest_w;
    logic          split;
    logic [AB-1:0] split_size, split_hdr;
    logic [SW-1:0] pick_size_w, res_w, in_size_w;
    logic [SW:0]   lim_w, bp_w, need_w;
    logic          grow_fail;
    logic          mprev, mnext, table_full;
    logic [AB-1:0] merged_prev, merged_next, merged_both;
    logic [SW-1:0] ba_w;

    fla_ram #(
        .WIDTH (2*AB),
        .DEPTH (FREE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_addr = ram_rdata[2*AB-1:AB];
    assign rd_size = ram_rdata[AB-1:0];
    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);

    assign fits   = SW'(rd_size) >= SW'(req_reg);
    assign better = rd_size < pick_size_reg;

    assign rest_w      = SW'(pick_size_reg) - SW'(req_reg);
    assign split       = rest_w > SW'(HEADER_BYTES);
    assign split_size  = AB'(rest_w) - HB;
    assign split_hdr   = pick_addr_reg + pick_size_reg - AB'(req_reg);
    assign pick_size_w = SW'(pick_size_reg);

    assign lim_w     = ((SW+1)'(heap_limit_reg) < AMASK) ? (SW+1)'(heap_limit_reg) : AMASK;
    assign bp_w      = (SW+1)'(bp_reg);
    assign need_w    = (SW+1)'(HEADER_BYTES) + (SW+1)'(req_reg);
    assign grow_fail = (bp_w > lim_w) || (need_w > (lim_w - bp_w));

    assign mnext = next_valid_reg && ((hdr_reg + HB + AB'(size_in_reg)) == next_addr_reg);
    assign mprev = (idx_reg != '0) && ((prev_addr_reg + HB + prev_size_reg) == hdr_reg);
    assign table_full  = count_reg >= CW'(FREE_SLOTS);
    assign merged_prev = prev_size_reg + HB + AB'(size_in_reg);
    assign merged_next = AB'(size_in_reg) + HB + next_size_reg;
    assign merged_both = merged_prev + HB + next_size_reg;
    assign in_size_w   = SW'(size_in_reg);

    assign ba_w  = SW'(block_address);
    assign res_w = SW'(res_addr_reg);

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[IW-1:0];
        ram_wdata = '0;
        ram_raddr = idx_reg[IW-1:0];
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (mode == fla_pkg::MODE_ALLOC) ? S_A_RD : S_F_RD;
                end
            end
            S_A_RD:
            begin
                state_next = (idx_reg < count_reg) ? S_A_EV : S_A_APPLY;
            end
            S_A_EV:
            begin
                if (fits && !found_reg && fit_policy_reg != fla_pkg::FIT_BEST)
                begin
                    state_next = S_A_APPLY;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_A_APPLY:
            begin
                if (found_reg && split)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pick_idx_reg[IW-1:0];
                    ram_wdata = {pick_addr_reg, split_size};
                    state_next = S_DONE;
                end
                else if (found_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_F_RD:
            begin
                state_next = (idx_reg < count_reg) ? S_F_EV : S_F_APPLY;
            end
            S_F_EV:
            begin
                state_next = (rd_addr <= hdr_reg) ? S_F_RD : S_F_APPLY;
            end
            S_F_APPLY:
            begin
                priority if (!mnext && !mprev && table_full)
                begin
                    state_next = S_DONE;
                end
                else if (mprev && mnext)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_dec[IW-1:0];
                    ram_wdata = {prev_addr_reg, merged_both};
                    state_next = S_SH_RD;
                end
                else if (mprev)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_dec[IW-1:0];
                    ram_wdata = {prev_addr_reg, merged_prev};
                    state_next = S_DONE;
                end
                else if (mnext)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {hdr_reg, merged_next};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                if (!shift_up_reg)
                begin
                    ram_raddr  = idx_inc[IW-1:0];
                    state_next = (idx_inc < count_reg) ? S_SH_WR : S_DONE;
                end
                else if (idx_reg > ins_pos_reg)
                begin
                    ram_raddr  = idx_dec[IW-1:0];
                    state_next = S_SH_WR;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ins_entry_reg;
                    state_next = S_DONE;
                end
            end
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                state_next = S_SH_RD;
            end
            S_DONE:
            begin
                if (!out_valid || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            fit_policy_reg     <= 1'b0;
            heap_limit_reg     <= 32'hFFFF_FFFF;
            bp_reg             <= '0;
            seg_bytes_reg      <= '0;
            free_tot_reg       <= '0;
            count_reg          <= '0;
            idx_reg            <= '0;
            ins_pos_reg        <= '0;
            shift_up_reg       <= 1'b0;
            req_reg            <= '0;
            size_in_reg        <= '0;
            hdr_reg            <= '0;
            found_reg          <= 1'b0;
            pick_idx_reg       <= '0;
            pick_addr_reg      <= '0;
            pick_size_reg      <= '0;
            prev_addr_reg      <= '0;
            prev_size_reg      <= '0;
            next_valid_reg     <= 1'b0;
            next_addr_reg      <= '0;
            next_size_reg      <= '0;
            ins_entry_reg      <= '0;
            res_addr_reg       <= '0;
            res_status_reg     <= fla_pkg::ST_OK;
            out_valid          <= 1'b0;
            result_address     <= '0;
            status             <= fla_pkg::ST_OK;
            data_segment_bytes <= '0;
            free_space_bytes   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fla_pkg::CFG_FIT_POLICY: fit_policy_reg <= cfg_data[0];
                    fla_pkg::CFG_HEAP_BASE:  bp_reg <= AB'(SW'(cfg_data));
                    fla_pkg::CFG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall && state_reg != S_DONE)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg        <= request_size;
                        size_in_reg    <= block_size;
                        hdr_reg        <= AB'(ba_w) - HB;
                        idx_reg        <= '0;
                        found_reg      <= 1'b0;
                        next_valid_reg <= 1'b0;
                        res_addr_reg   <= '0;
                        res_status_reg <= fla_pkg::ST_OK;
                    end
                end
                S_A_RD: ;
                S_A_EV:
                begin
                    if (fits && (!found_reg ||
                        (fit_policy_reg == fla_pkg::FIT_BEST && better)))
                    begin
                        found_reg     <= 1'b1;
                        pick_idx_reg  <= idx_reg;
                        pick_addr_reg <= rd_addr;
                        pick_size_reg <= rd_size;
                    end
                    idx_reg <= idx_inc;
                end
                S_A_APPLY:
                begin
                    if (found_reg && split)
                    begin
                        res_addr_reg <= split_hdr + HB;
                        free_tot_reg <= free_tot_reg - (32'(HEADER_BYTES) + 32'(req_reg));
                    end
                    else if (found_reg)
                    begin
                        res_addr_reg <= pick_addr_reg + HB;
                        free_tot_reg <= free_tot_reg -
                            (32'(HEADER_BYTES) + pick_size_w[31:0]);
                        idx_reg      <= pick_idx_reg;
                        shift_up_reg <= 1'b0;
                    end
                    else if (grow_fail)
                    begin
                        res_status_reg <= fla_pkg::ST_HEAP_FULL;
                    end
                    else
                    begin
                        res_addr_reg  <= bp_reg + HB;
                        bp_reg        <= AB'(bp_w + need_w);
                        seg_bytes_reg <= seg_bytes_reg +
                            (32'(HEADER_BYTES) + 32'(req_reg));
                    end
                end
                S_F_RD:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        next_valid_reg <= 1'b0;
                    end
                end
                S_F_EV:
                begin
                    if (rd_addr <= hdr_reg)
                    begin
                        prev_addr_reg <= rd_addr;
                        prev_size_reg <= rd_size;
                        idx_reg       <= idx_inc;
                    end
                    else
                    begin
                        next_valid_reg <= 1'b1;
                        next_addr_reg  <= rd_addr;
                        next_size_reg  <= rd_size;
                    end
                end
                S_F_APPLY:
                begin
                    if (!mnext && !mprev && table_full)
                    begin
                        res_status_reg <= fla_pkg::ST_TABLE_FULL;
                    end
                    else
                    begin
                        free_tot_reg <= free_tot_reg +
                            (32'(HEADER_BYTES) + in_size_w[31:0]);
                        if (mprev && mnext)
                        begin
                            shift_up_reg <= 1'b0;
                        end
                        else if (!mprev && !mnext)
                        begin
                            ins_entry_reg <= {hdr_reg, AB'(size_in_reg)};
                            ins_pos_reg   <= idx_reg;
                            idx_reg       <= count_reg;
                            shift_up_reg  <= 1'b1;
                        end
                    end
                end
                S_SH_RD:
                begin
                    if (!shift_up_reg && !(idx_inc < count_reg))
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                    else if (shift_up_reg && !(idx_reg > ins_pos_reg))
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                S_SH_WR:
                begin
                    idx_reg <= shift_up_reg ? idx_dec : idx_inc;
                end
                S_DONE:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_valid          <= 1'b1;
                        result_address     <= res_w[31:0];
                        status             <= res_status_reg;
                        data_segment_bytes <= seg_bytes_reg;
                        free_space_bytes   <= free_tot_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> design/fla_ram.sv
// Generic single write port, single read port RAM with registered read data.
module fla_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
